// ----- hw/rtl/text_to_integer_any_base_core_macros.svh -----
// Assertion macros used by the converter top level.
`ifndef TEXT_TO_INTEGER_ANY_BASE_CORE_MACROS_SVH
`define TEXT_TO_INTEGER_ANY_BASE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define T2I_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define T2I_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/t2i_pkg.sv -----
// Shared constants and types of the text-to-integer converter.
package t2i_pkg;

    localparam int MAX_DIGITS    = 16;
    localparam int VALUE_WIDTH   = 32;
    localparam int IDX_W         = $clog2(MAX_DIGITS);
    localparam int RADIX_W       = $clog2(MAX_DIGITS + 1);
    localparam int OUT_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int DIGIT_COUNT_W = 5;
    localparam int SYMBOLS_W     = 64;
    localparam int CFG_ADDR_W    = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_DIGIT_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [DIGIT_COUNT_W-1:0] RST_DIGIT_COUNT  = 5'd10;
    localparam logic [SYMBOLS_W-1:0]     RST_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [SYMBOLS_W-1:0]     RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic               base_invalid;
        logic               digit_hit;
        logic [IDX_W-1:0]   digit_idx;
        logic [RADIX_W-1:0] radix;
    } t_alpha_info;

endpackage

// ----- hw/rtl/t2i_alphabet.sv -----
// Alphabet registers, validity check and parallel digit matcher.
module t2i_alphabet
    import t2i_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [SYMBOLS_W-1:0]     i_cfg_wdata,
    input  logic [7:0]               i_text_byte,
    output t_alpha_info              o_info
);

    logic [DIGIT_COUNT_W-1:0] r_digit_count;
    logic [SYMBOLS_W-1:0]     r_symbols_low;
    logic [SYMBOLS_W-1:0]     r_symbols_high;
    logic                     w_base_invalid;
    logic [RADIX_W-1:0]       w_radix;
    logic [7:0]               w_sym [MAX_DIGITS];
    logic                     w_hit;
    logic [IDX_W-1:0]         w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count  <= RST_DIGIT_COUNT;
            r_symbols_low  <= RST_SYMBOLS_LOW;
            r_symbols_high <= RST_SYMBOLS_HIGH;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_DIGIT_COUNT:  r_digit_count  <= i_cfg_wdata[DIGIT_COUNT_W-1:0];
                    CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_wdata;
                    CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Cap the radix at the alphabet size.
    assign w_radix = (r_digit_count > DIGIT_COUNT_W'(MAX_DIGITS)) ? RADIX_W'(MAX_DIGITS)
                                                                 : RADIX_W'(r_digit_count);

    for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_sym
        if (k < 8) begin : g_low
            assign w_sym[k] = r_symbols_low[8*k +: 8];
        end else begin : g_high
            assign w_sym[k] = r_symbols_high[8*(k-8) +: 8];
        end
    end

    always_comb begin
        w_base_invalid = (w_radix < RADIX_W'(2));
        for (int a = 0; a < MAX_DIGITS; a++) begin
            if (RADIX_W'(a) < w_radix) begin
                if (w_sym[a] < CH_SPACE || w_sym[a] > CH_TILDE
                        || w_sym[a] == CH_PLUS || w_sym[a] == CH_MINUS) begin
                    w_base_invalid = 1'b1;
                end
                for (int b = a + 1; b < MAX_DIGITS; b++) begin
                    if (RADIX_W'(b) < w_radix && w_sym[b] == w_sym[a]) begin
                        w_base_invalid = 1'b1;
                    end
                end
            end
        end
    end

    // Scan from the top so the lowest matching index wins.
    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
            if (RADIX_W'(k) < w_radix && w_sym[k] == i_text_byte) begin
                w_hit = 1'b1;
                w_idx = IDX_W'(k);
            end
        end
    end

    assign o_info.base_invalid = w_base_invalid;
    assign o_info.digit_hit    = w_hit;
    assign o_info.digit_idx    = w_idx;
    assign o_info.radix        = w_radix;

endmodule

// ----- hw/rtl/t2i_parse.sv -----
// Parse state machine, sign flag and multiply-add accumulator.
module t2i_parse
    import t2i_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [7:0]                    i_text_byte,
    input  t_alpha_info                   i_info,
    output logic signed [VALUE_WIDTH-1:0] o_number_value,
    output logic                          o_base_invalid
);

    typedef enum logic [3:0] {
        PH_SPACE = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_STOP  = 4'b1000
    } t_phase;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic                   r_negative;
    logic                   n_negative;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic [VALUE_WIDTH-1:0] n_acc;
    logic [VALUE_WIDTH-1:0] w_mac;
    logic                   w_ws;
    logic                   w_sign;
    logic                   w_digit;

    assign w_ws = (i_text_byte == CH_SPACE) || (i_text_byte >= CH_TAB && i_text_byte <= CH_CR);

    // Fall through the phases the way the byte allows.
    always_comb begin
        case (r_phase)
            PH_SPACE: w_sign = !w_ws;
            PH_SIGN:  w_sign = 1'b1;
            default:  w_sign = 1'b0;
        endcase
        w_digit = (w_sign && i_text_byte != CH_PLUS && i_text_byte != CH_MINUS)
                  || (r_phase == PH_DIGIT);
    end

    assign w_mac = VALUE_WIDTH'(r_acc * VALUE_WIDTH'(i_info.radix))
                   + VALUE_WIDTH'(i_info.digit_idx);

    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_acc      = r_acc;
        if (i_text_byte == CH_NUL) begin
            n_phase    = PH_SPACE;
            n_negative = 1'b0;
            n_acc      = '0;
        end else if (w_digit) begin
            if (i_info.digit_hit) begin
                n_phase = PH_DIGIT;
                n_acc   = w_mac;
            end else begin
                n_phase = PH_STOP;
            end
        end else if (w_sign) begin
            n_phase = PH_SIGN;
            if (i_text_byte == CH_MINUS) begin
                n_negative = !r_negative;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SPACE;
            r_negative <= 1'b0;
            r_acc      <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_acc      <= n_acc;
        end
    end

    assign o_base_invalid = i_info.base_invalid;
    assign o_number_value = i_info.base_invalid ? '0
                          : (r_negative ? (VALUE_WIDTH'(0) - r_acc) : r_acc);

endmodule

// ----- hw/rtl/text_to_integer_any_base_core.sv -----
// Top level of the streaming text-to-integer converter in a configurable base.
//
// Text arrives one byte per beat on the s_axis channel. Leading whitespace is
// skipped, a run of '+' and '-' sets the sign, and digits of the configured
// alphabet build the value. A zero byte ends the string and produces one beat
// on the m_axis channel: the signed value in tdata and the invalid-alphabet
// flag in tuser. Other bytes produce no output beat.
// The alphabet (radix and up to 16 symbols) is loaded through the write port
// and must be written while no string is in flight.
// Throughput: one byte per cycle, except while a zero byte waits for the
// result register. The parse state and the accumulator update with a single
// multiply-add and the 16-way symbol compare. A zero byte's result passes
// through the input register and then the result register to m_axis.
// Reset (synchronous, active low) restores the decimal alphabet "0123456789"
// and clears the parse state; no sweep is needed.
// When the receiver stalls, non-terminating bytes keep flowing; a zero byte
// that meets an occupied result register waits in the input register with
// s_axis_tready low until the pending result beat is taken.
`include "text_to_integer_any_base_core_macros.svh"

module text_to_integer_any_base_core
    import t2i_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [SYMBOLS_W-1:0]   i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [7:0] text_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [VALUE_WIDTH-1:0] number_value
    output logic                   m_axis_tuser   // [0] base_invalid
);

    logic                          r_in_valid;
    logic [7:0]                    r_in_byte;
    logic                          r_out_valid;
    logic [VALUE_WIDTH-1:0]        r_out_value;
    logic                          r_out_invalid;
    logic                          w_in_zero;
    logic                          w_slot_free;
    logic                          w_fire;
    t_alpha_info                   w_info;
    logic signed [VALUE_WIDTH-1:0] w_value;
    logic                          w_invalid;

    assign w_in_zero     = (r_in_byte == CH_NUL);
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && (!w_in_zero || w_slot_free);
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    t2i_alphabet u_alphabet (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_text_byte (r_in_byte),
        .o_info      (w_info)
    );

    t2i_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_text_byte    (r_in_byte),
        .i_info         (w_info),
        .o_number_value (w_value),
        .o_base_invalid (w_invalid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_in_zero) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_in_zero) begin
            r_out_value   <= w_value;
            r_out_invalid <= w_invalid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_value);
    assign m_axis_tuser  = r_out_invalid;

    `T2I_ASSERT_NOW(a_invalid_forces_zero, i_clk, i_rst_n, r_out_valid && r_out_invalid, r_out_value == '0, "invalid alphabet result carries a nonzero value")
    `T2I_ASSERT_NEXT(a_zero_byte_emits, i_clk, i_rst_n, w_fire && w_in_zero, r_out_valid, "terminating byte produced no result beat")
    `T2I_ASSERT_NEXT(a_blocked_byte_held, i_clk, i_rst_n, r_in_valid && !w_fire, r_in_valid && $stable(r_in_byte), "blocked byte lost from input register")

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the streaming text-to-integer converter.
`timescale 1ns / 1ps

module tb;
    import t2i_pkg::*;

    localparam int TEXT_BEATS  = 1024;
    localparam int QUIET_AFTER = 880;
    localparam int DRAIN_EXTRA = 4;

    typedef enum logic [1:0] {
        SCAN_SPACE,
        SCAN_SIGN,
        SCAN_DIGITS,
        SCAN_DONE
    } t_scan_phase;

    typedef enum logic [1:0] {
        ROW_TEXT,
        ROW_KNOWN,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   invalid;
    } t_conversion;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [SYMBOLS_W-1:0]   data;
        logic [VALUE_WIDTH-1:0] value;
        logic                   invalid;
    } t_step_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = CFG_DIGIT_COUNT;
    logic [SYMBOLS_W-1:0]   i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;   // [7:0] text_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [VALUE_WIDTH-1:0] number_value
    logic                   m_axis_tuser;         // [0] base_invalid

    // Known result that travels along with the current text beat
    logic                   row_typed   = 1'b0;
    logic [VALUE_WIDTH-1:0] row_value   = '0;
    logic                   row_invalid = 1'b0;

    // Predictor copy of the registers and the parse state
    logic [DIGIT_COUNT_W-1:0] reg_count   = RST_DIGIT_COUNT;
    logic [SYMBOLS_W-1:0]     reg_low     = RST_SYMBOLS_LOW;
    logic [SYMBOLS_W-1:0]     reg_high    = RST_SYMBOLS_HIGH;
    t_scan_phase              par_phase   = SCAN_SPACE;
    logic                     par_negative = 1'b0;
    logic [VALUE_WIDTH-1:0]   par_acc     = '0;

    t_conversion expected_numbers[$];
    int          fails       = 0;
    int          sent_beats  = 0;
    int          stall_left  = 0;
    bit          quiet_tail  = 1'b0;

    t_step_row directed_rows [30] = '{
        '{kind: ROW_KNOWN, data: CH_NUL, default: '0},
        '{kind: ROW_TEXT, data: CH_TAB, default: '0},
        '{kind: ROW_TEXT, data: CH_CR, default: '0},
        '{kind: ROW_TEXT, data: CH_SPACE, default: '0},
        '{kind: ROW_TEXT, data: CH_MINUS, default: '0},
        '{kind: ROW_TEXT, data: CH_PLUS, default: '0},
        '{kind: ROW_TEXT, data: 64'h39, default: '0},
        '{kind: ROW_TEXT, data: 64'h38, default: '0},
        '{kind: ROW_TEXT, data: 64'h78, default: '0},
        '{kind: ROW_TEXT, data: 64'h35, default: '0},
        '{kind: ROW_KNOWN, data: CH_NUL, value: -32'd98, default: '0},
        '{kind: ROW_TEXT, data: 64'hFF, default: '0},
        '{kind: ROW_TEXT, data: 64'h31, default: '0},
        '{kind: ROW_KNOWN, data: CH_NUL, default: '0},
        // single-symbol alphabet
        '{kind: ROW_REG, addr: CFG_DIGIT_COUNT, data: 64'd1, default: '0},
        '{kind: ROW_KNOWN, data: CH_NUL, invalid: 1'b1, default: '0},
        // radix above the cap, hex alphabet
        '{kind: ROW_REG, addr: CFG_DIGIT_COUNT, data: 64'd31, default: '0},
        '{kind: ROW_REG, addr: CFG_SYMBOLS_HIGH, data: 64'h6665_6463_6261_3938, default: '0},
        '{kind: ROW_TEXT, data: CH_MINUS, default: '0},
        '{kind: ROW_TEXT, data: 64'h31, default: '0},
        '{kind: ROW_TEXT, data: 64'h67, default: '0},
        '{kind: ROW_KNOWN, data: CH_NUL, value: 32'hFFFF_FFFF, default: '0},
        // sign character inside the alphabet
        '{kind: ROW_REG, addr: CFG_SYMBOLS_HIGH, data: 64'h6665_6463_6261_392B, default: '0},
        '{kind: ROW_TEXT, data: 64'h31, default: '0},
        '{kind: ROW_KNOWN, data: CH_NUL, invalid: 1'b1, default: '0},
        // high byte as a symbol, and the matching text byte
        '{kind: ROW_REG, addr: CFG_SYMBOLS_HIGH, data: 64'h6665_6463_6261_3980, default: '0},
        '{kind: ROW_TEXT, data: 64'h80, default: '0},
        '{kind: ROW_KNOWN, data: CH_NUL, invalid: 1'b1, default: '0},
        // repeated symbol
        '{kind: ROW_REG, addr: CFG_SYMBOLS_HIGH, data: 64'h6665_6463_6261_3930, default: '0},
        '{kind: ROW_KNOWN, data: CH_NUL, invalid: 1'b1, default: '0}
    };

    text_to_integer_any_base_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int live_radix();
        return (reg_count > MAX_DIGITS) ? MAX_DIGITS : int'(reg_count);
    endfunction

    function automatic logic [7:0] symbol_at(input int k);
        return (k < 8) ? reg_low[8*k +: 8] : reg_high[8*(k-8) +: 8];
    endfunction

    task automatic parse_text(input logic [7:0] ch, output bit emit, output t_conversion res);
        int         idx;
        bit         ok;
        logic [7:0] s;
        emit = 1'b0;
        res  = '0;
        if (ch == CH_NUL) begin
            ok = live_radix() >= 2;
            for (int a = 0; a < live_radix(); a++) begin
                s = symbol_at(a);
                if (s < CH_SPACE || s > CH_TILDE || s == CH_PLUS || s == CH_MINUS)
                    ok = 1'b0;
                for (int b = a + 1; b < live_radix(); b++)
                    if (symbol_at(b) == s)
                        ok = 1'b0;
            end
            emit = 1'b1;
            if (ok)
                res.value = par_negative ? -par_acc : par_acc;
            res.invalid  = !ok;
            par_phase    = SCAN_SPACE;
            par_negative = 1'b0;
            par_acc      = '0;
            return;
        end
        if (par_phase == SCAN_SPACE) begin
            if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))
                return;
            par_phase = SCAN_SIGN;
        end
        if (par_phase == SCAN_SIGN) begin
            if (ch == CH_MINUS) begin
                par_negative = !par_negative;
                return;
            end
            if (ch == CH_PLUS)
                return;
            par_phase = SCAN_DIGITS;
        end
        if (par_phase == SCAN_DIGITS) begin
            // lowest matching index wins
            idx = -1;
            for (int k = live_radix() - 1; k >= 0; k--)
                if (symbol_at(k) == ch)
                    idx = k;
            if (idx < 0)
                par_phase = SCAN_DONE;
            else
                par_acc = par_acc * VALUE_WIDTH'(live_radix()) + VALUE_WIDTH'(idx);
        end
    endtask

    // Predict on accepted text beats, track register writes, check result beats
    always @(posedge i_clk) begin
        t_conversion want;
        bit          emit;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_numbers.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat: value %h invalid %b",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    want = expected_numbers.pop_front();
                    if (m_axis_tdata !== OUT_TDATA_W'(want.value) ||
                        m_axis_tuser !== want.invalid) begin
                        fails++;
                        if (fails <= 10)
                            $display("result mismatch: value exp %h (%0d) got %h, invalid exp %b got %b",
                                     want.value, $signed(want.value), m_axis_tdata,
                                     want.invalid, m_axis_tuser);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_DIGIT_COUNT:  reg_count = i_cfg_wdata[DIGIT_COUNT_W-1:0];
                    CFG_SYMBOLS_LOW:  reg_low   = i_cfg_wdata;
                    CFG_SYMBOLS_HIGH: reg_high  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_text(s_axis_tdata, emit, want);
                if (emit) begin
                    if (row_typed) begin
                        want.value   = row_value;
                        want.invalid = row_invalid;
                    end
                    expected_numbers.push_back(want);
                end
            end
        end
    end

    // Receiver stalls in random bursts; no new burst starts in the quiet tail
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] ch, input bit typed = 1'b0,
                             input logic [VALUE_WIDTH-1:0] value = '0,
                             input bit invalid = 1'b0);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        row_typed     <= typed;
        row_value     <= value;
        row_invalid   <= invalid;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_beats++;
        if (sent_beats >= QUIET_AFTER)
            quiet_tail = 1'b1;
    endtask

    // Hold the sender until every result is out and the pipeline is empty
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_EXTRA) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [SYMBOLS_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]           pool [93];
        logic [7:0]           gen_syms [16];
        logic [7:0]           swap;
        logic [4:0]           gen_count;
        logic [SYMBOLS_W-1:0] gen_low;
        logic [SYMBOLS_W-1:0] gen_high;
        int                   kind;
        int                   eff;
        int                   pos;
        int                   n;
        int                   j;

        n = 0;
        for (int c = CH_SPACE; c <= CH_TILDE; c++)
            if (c != CH_PLUS && c != CH_MINUS)
                pool[n++] = 8'(c);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < $size(directed_rows); r++) begin
            if (directed_rows[r].kind == ROW_REG) begin
                if (r == 0 || directed_rows[r-1].kind != ROW_REG)
                    wait_results_drained();
                write_register(directed_rows[r].addr, directed_rows[r].data);
            end else begin
                send_byte(directed_rows[r].data[7:0], directed_rows[r].kind == ROW_KNOWN,
                          directed_rows[r].value, directed_rows[r].invalid);
            end
        end

        while (sent_beats < TEXT_BEATS) begin
            // New alphabet for this phase: mostly valid, some extremes and broken ones
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    case ($urandom_range(0, 5))
                        0: gen_count = 5'd0;
                        1: gen_count = 5'd1;
                        2: gen_count = 5'd2;
                        3: gen_count = 5'd16;
                        4: gen_count = 5'd17;
                        default: gen_count = 5'd31;
                    endcase
                end
                1: gen_count = 5'($urandom_range(0, 31));
                2: gen_count = 5'($urandom_range(2, 16));
                default: gen_count = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                                  : 5'($urandom_range(2, 16));
            endcase
            eff = (gen_count > MAX_DIGITS) ? MAX_DIGITS : int'(gen_count);
            for (int i = 0; i < 16; i++) begin
                j = $urandom_range(i, 92);
                swap = pool[i];
                pool[i] = pool[j];
                pool[j] = swap;
                gen_syms[i] = (i < eff) ? pool[i] : 8'($urandom_range(0, 255));
            end
            if (kind == 1) begin
                for (int i = 0; i < 16; i++)
                    gen_syms[i] = 8'($urandom_range(0, 255));
            end else if (kind == 2) begin
                pos = $urandom_range(0, eff - 1);
                case ($urandom_range(0, 4))
                    0: gen_syms[pos] = gen_syms[(pos + 1) % eff];
                    1: gen_syms[pos] = CH_PLUS;
                    2: gen_syms[pos] = CH_MINUS;
                    3: gen_syms[pos] = 8'($urandom_range(0, 31));
                    default: gen_syms[pos] = 8'($urandom_range(127, 255));
                endcase
            end
            for (int i = 0; i < 8; i++) begin
                gen_low[8*i +: 8]  = gen_syms[i];
                gen_high[8*i +: 8] = gen_syms[i+8];
            end
            wait_results_drained();
            write_register(CFG_DIGIT_COUNT, SYMBOLS_W'(gen_count));
            write_register(CFG_SYMBOLS_LOW, gen_low);
            write_register(CFG_SYMBOLS_HIGH, gen_high);

            repeat ($urandom_range(4, 12)) begin
                if (eff == 0 || $urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(1, 255)));
                end else begin
                    repeat ($urandom_range(0, 3)) begin
                        j = $urandom_range(0, 5);
                        send_byte((j == 5) ? CH_SPACE : 8'(CH_TAB + j));
                    end
                    repeat ($urandom_range(0, 3))
                        send_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    repeat ($urandom_range(0, 10))
                        send_byte(gen_syms[$urandom_range(0, eff - 1)]);
                    repeat ($urandom_range(0, 2))
                        send_byte(8'($urandom_range(1, 255)));
                end
                send_byte(CH_NUL);
            end
        end

        wait_results_drained();
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/t2i_pkg.sv
hw/rtl/t2i_alphabet.sv
hw/rtl/t2i_parse.sv
hw/rtl/text_to_integer_any_base_core.sv
verif/tb.sv
